>>> rtl/sha1bs_pkg.sv
// shared constants and types for the sha-1 byte stream hasher
package sha1bs_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [4:0] LEN_WORD  = 5'd14;
    localparam logic [4:0] END_WORD  = 5'd16;

    typedef logic [DIGEST_WORDS-1:0][31:0] digest_t;

    localparam digest_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    typedef struct packed {
        logic done;
    } core_stat_t;

endpackage

>>> rtl/sha1bs_ram.sv
// generic single-port ram with registered read
module sha1bs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sha1bs_core.sv
// sha-1 compression engine: one round per cycle, schedule window, chaining words
module sha1bs_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha1bs_pkg::core_ctrl_t ctrl,
    output sha1bs_pkg::core_stat_t stat,
    output logic [3:0]           rd_addr,
    input  logic [31:0]          rd_data,
    output sha1bs_pkg::digest_t  hash
);

    import sha1bs_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } cstate_t;

    cstate_t       state_reg, state_next;
    logic [6:0]    rnd_reg, rnd_next;
    digest_t       h_reg, h_next;
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]   a_next, b_next, c_next, d_next, e_next;
    logic [31:0]   win_reg [BLOCK_WORDS];
    logic [31:0]   win_next [BLOCK_WORDS];
    logic [31:0]   w_cur, x_cur, f_cur, k_cur, t_cur;

    always_comb
    begin
        x_cur = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        if (rnd_reg < 7'(BLOCK_WORDS))
            w_cur = rd_data;
        else
            w_cur = {x_cur[30:0], x_cur[31]};

        if (rnd_reg < 7'd20)
        begin
            f_cur = (b_reg & c_reg) | (~b_reg & d_reg);
            k_cur = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_cur = b_reg ^ c_reg ^ d_reg;
            k_cur = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_cur = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_cur = K2;
        end
        else
        begin
            f_cur = b_reg ^ c_reg ^ d_reg;
            k_cur = K3;
        end
        t_cur = {a_reg[26:0], a_reg[31:27]} + f_cur + e_reg + k_cur + w_cur;
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        h_next     = h_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        win_next   = win_reg;

        case (state_reg)
            C_IDLE:
            begin
                if (ctrl.init)
                begin
                    h_next = H_INIT;
                end
                else if (ctrl.start)
                begin
                    a_next     = h_reg[0];
                    b_next     = h_reg[1];
                    c_next     = h_reg[2];
                    d_next     = h_reg[3];
                    e_next     = h_reg[4];
                    rnd_next   = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                a_next = t_cur;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[BLOCK_WORDS-1] = w_cur;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(ROUNDS - 1))
                    state_next = C_ADD;
            end
            C_ADD:
            begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                h_next[4]  = h_reg[4] + e_reg;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            h_reg     <= H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        win_reg <= win_next;
    end

    // prefetch the next block word so it lands with its round
    assign rd_addr   = (state_reg == C_ROUND) ? (rnd_reg[3:0] + 4'd1) : 4'd0;
    assign stat.done = (state_reg == C_ADD);
    assign hash      = h_reg;

endmodule

>>> rtl/sha1_byte_stream_hasher.sv
// top level of the sha-1 byte stream hasher: byte packing, padding, digest output
//
// input channel: in_valid / in_stall with command and data_byte. an absorb
// transfer appends one message byte; a finish transfer pads the message and
// produces the 160-bit digest as five output transfers.
// output channel: out_valid / out_stall with digest_word, word_index and
// last_word; words come out most significant first, last_word on index 4.
// bytes are packed into 32-bit words and written into a 16-word block ram;
// the compression engine reads that ram back, one round per cycle.
// absorbs are taken back to back, except that the 64th byte of a block
// stalls the input for a compression (start, 80 rounds, chaining add).
// a finish runs the padding writes up to the block end, one compression
// (two when 56 or more bytes sit in the block, plus 16 more padding writes),
// then loads the first digest word; the five words then leave at
// one per cycle while out_stall is low and hold while it is high.
// in_stall is high whenever the block is busy with a compression, padding
// or digest output. reset restores the initial chaining words and clears the
// byte and bit counters; the block ram contents need no clearing since every
// word is written before the engine reads it.
module sha1_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    import sha1bs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_START,
        S_COMP,
        S_OUT
    } state_t;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;       // where to go after a compression
    logic [5:0]  fill_reg, fill_next;     // bytes held in the block
    logic [23:0] acc_reg, acc_next;       // leading bytes of the word being built
    logic [63:0] bitcnt_reg, bitcnt_next;
    logic [4:0]  wptr_reg, wptr_next;     // padding write pointer
    logic        extra_reg, extra_next;   // length does not fit, extra block first
    logic        out_valid_reg, out_valid_next;
    logic [31:0] digest_word_reg, digest_word_next;
    logic [2:0]  word_index_reg, word_index_next;
    logic        last_word_reg, last_word_next;

    logic        ram_we;
    logic [3:0]  ram_addr, wr_addr;
    logic [31:0] ram_wdata, ram_rdata;
    logic [3:0]  core_addr;
    core_ctrl_t  core_ctrl;
    core_stat_t  core_stat;
    digest_t     hash;
    logic        in_xfer, out_xfer;
    logic [31:0] pad_word;

    sha1bs_ram #(
        .WIDTH (32),
        .DEPTH (BLOCK_WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    sha1bs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (core_ctrl),
        .stat    (core_stat),
        .rd_addr (core_addr),
        .rd_data (ram_rdata),
        .hash    (hash)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    // word holding the 0x80 marker, earlier bytes of the word kept
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {acc_reg[23:16], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {acc_reg[23:8], PAD_BYTE, 8'h0};
            default: pad_word = {acc_reg, PAD_BYTE};
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        fill_next        = fill_reg;
        acc_next         = acc_reg;
        bitcnt_next      = bitcnt_reg;
        wptr_next        = wptr_reg;
        extra_next       = extra_reg;
        out_valid_next   = out_valid_reg;
        digest_word_next = digest_word_reg;
        word_index_next  = word_index_reg;
        last_word_next   = last_word_reg;
        ram_we           = 1'b0;
        wr_addr          = fill_reg[5:2];
        ram_wdata        = '0;
        core_ctrl.start  = 1'b0;
        core_ctrl.init   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (command == CMD_ABSORB)
                    begin
                        case (fill_reg[1:0])
                            2'd0:    acc_next[23:16] = data_byte;
                            2'd1:    acc_next[15:8]  = data_byte;
                            2'd2:    acc_next[7:0]   = data_byte;
                            default: acc_next        = acc_reg;
                        endcase
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {acc_reg, data_byte};
                        end
                        bitcnt_next = {bitcnt_reg[63:3] + 61'd1, bitcnt_reg[2:0]};
                        fill_next   = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            ret_next   = S_IDLE;
                            state_next = S_START;
                        end
                    end
                    else if (command == CMD_FINISH)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = pad_word;
                        wptr_next  = {1'b0, fill_reg[5:2]} + 5'd1;
                        extra_next = (fill_reg[5:3] == 3'b111);
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                if (wptr_reg == END_WORD)
                begin
                    ret_next   = extra_reg ? S_PAD : S_OUT;
                    extra_next = 1'b0;
                    wptr_next  = '0;
                    state_next = S_START;
                end
                else
                begin
                    ram_we  = 1'b1;
                    wr_addr = wptr_reg[3:0];
                    if (extra_reg || (wptr_reg < LEN_WORD))
                        ram_wdata = '0;
                    else if (wptr_reg == LEN_WORD)
                        ram_wdata = bitcnt_reg[63:32];
                    else
                        ram_wdata = bitcnt_reg[31:0];
                    wptr_next = wptr_reg + 5'd1;
                end
            end
            S_START:
            begin
                core_ctrl.start = 1'b1;
                state_next      = S_COMP;
            end
            S_COMP:
            begin
                if (core_stat.done)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ret_reg;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next   = 1'b1;
                    digest_word_next = hash[0];
                    word_index_next  = '0;
                    last_word_next   = 1'b0;
                end
                else if (out_xfer)
                begin
                    if (word_index_reg == 3'(DIGEST_WORDS - 1))
                    begin
                        // digest delivered, start over for the next message
                        out_valid_next = 1'b0;
                        core_ctrl.init = 1'b1;
                        bitcnt_next    = '0;
                        fill_next      = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        digest_word_next = hash[word_index_reg + 3'd1];
                        word_index_next  = word_index_reg + 3'd1;
                        last_word_next   = (word_index_reg == 3'(DIGEST_WORDS - 2));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the engine owns the ram port while it starts and runs
    assign ram_addr = ((state_reg == S_START) || (state_reg == S_COMP)) ? core_addr : wr_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            fill_reg      <= '0;
            bitcnt_reg    <= '0;
            wptr_reg      <= '0;
            extra_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            bitcnt_reg    <= bitcnt_next;
            wptr_reg      <= wptr_next;
            extra_reg     <= extra_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        digest_word_reg <= digest_word_next;
        word_index_reg  <= word_index_next;
        last_word_reg   <= last_word_next;
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = digest_word_reg;
    assign word_index  = word_index_reg;
    assign last_word   = last_word_reg;

endmodule

>>> tb/sha1_tb_pkg.sv
// command codes shared by the sha-1 hasher testbench files
package sha1_tb_pkg;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } hash_cmd_t;

endpackage

>>> tb/sha1_digest_checker.sv
// channel monitor with a sha-1 digest predictor and per-word comparison
module sha1_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          mismatches,
    output int          outstanding
);
    import sha1_tb_pkg::*;

    localparam logic [4:0][31:0] SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                            32'hEFCDAB89, 32'h67452301};
    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam int         LEN_OFFSET  = 56;
    localparam int         BLOCK_BYTES = 64;
    localparam int         HASH_WORDS  = 5;
    localparam int         MAX_PRINTS  = 40;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic [31:0]  chain [HASH_WORDS];
    logic [63:0]  msg_bits;
    logic [31:0]  blk [16];
    logic [6:0]   fill;
    digest_beat_t expected_words [$];
    digest_beat_t want;

    function automatic logic [31:0] rotl32(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart_message();
        for (int i = 0; i < HASH_WORDS; i++)
            chain[i] = SHA1_IV[i];
        msg_bits = '0;
        fill     = '0;
    endtask

    // big-endian packing, byte n lands in word n/4
    task automatic store_byte(int pos, logic [7:0] b);
        blk[pos >> 2][8 * (3 - (pos & 3)) +: 8] = b;
    endtask

    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = blk[i];
        for (int i = 16; i < 80; i++)
            w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl32(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    task automatic absorb_byte(logic [7:0] b);
        store_byte(int'(fill), b);
        msg_bits += 64'd8;
        fill++;
        if (fill == BLOCK_BYTES)
        begin
            compress_block();
            fill = '0;
        end
    endtask

    // pad, maybe spill into an extra block, then queue the five digest words
    task automatic finish_message();
        int pos;
        pos = int'(fill);
        store_byte(pos, PAD_MARK);
        pos++;
        if (pos > LEN_OFFSET)
        begin
            while (pos < BLOCK_BYTES)
            begin
                store_byte(pos, 8'h00);
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < LEN_OFFSET)
        begin
            store_byte(pos, 8'h00);
            pos++;
        end
        blk[14] = msg_bits[63:32];
        blk[15] = msg_bits[31:0];
        compress_block();
        for (int i = 0; i < HASH_WORDS; i++)
            expected_words.push_back(digest_beat_t'{chain[i], 3'(i), (i == HASH_WORDS - 1)});
        restart_message();
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("checker: %s mismatch, got %08h, expected %08h", field, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            for (int i = 0; i < 16; i++)
                blk[i] = '0;
            expected_words.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected digest_word", digest_word, 32'h0);
                else
                begin
                    want = expected_words.pop_front();
                    if (digest_word !== want.word)
                        report_mismatch("digest_word", digest_word, want.word);
                    if (word_index !== want.index)
                        report_mismatch("word_index", 32'(word_index), 32'(want.index));
                    if (last_word !== want.last)
                        report_mismatch("last_word", 32'(last_word), 32'(want.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (hash_cmd_t'(command) == CMD_FINISH)
                    finish_message();
                else
                    absorb_byte(data_byte);
            end
            outstanding = expected_words.size();
        end
    end

endmodule

>>> tb/tb.sv
// testbench top for the sha-1 byte stream hasher: stimulus, flow control, verdict
module tb;
    import sha1_tb_pkg::*;

    // generous bound: a few hundred items, their block compressions, random
    // stalls on both sides and one long hold-off
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 320;
    // drain window after the last digest word, covers a full compression
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_OFF_CYCLES = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        command   = CMD_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int mismatches;
    int outstanding;
    int cycle_count   = 0;
    int items_sent    = 0;
    int words_taken   = 0;
    bit pressure_done = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sha1_byte_stream_hasher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    sha1_digest_checker digest_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // cycle count for the timeout and the quiet stretches, plus a tally of
    // digest words taken so the long hold-off lands mid-run
    always @(posedge clk)
    begin
        cycle_count++;
        if (out_valid && !out_stall)
            words_taken++;
    end

    // one stretch in four runs with no idling on either side
    function automatic bit quiet_stretch();
        return (cycle_count / 1500) % 4 == 3;
    endfunction

    // idle length: mostly none, often short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_stretch() || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // offer one transfer, hold it until taken, then maybe idle a while;
    // valid is only lowered when a gap follows, so back-to-back transfers
    // keep it high with no extra assignment in the same step
    task automatic send(hash_cmd_t cmd, logic [7:0] b);
        int gap;
        command   <= cmd;
        data_byte <= b;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        gap = pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // random message body of len bytes, closed by a finish with a junk byte
    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
            send(CMD_ABSORB, 8'($urandom_range(0, 255)));
        send(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // receiver: random stalls, plus one long hold-off while a digest is
    // waiting, so the block backs up and stalls the sender
    initial
    begin : receiver
        int hold;
        int n;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (!pressure_done && out_valid && words_taken >= 30)
            begin
                out_stall     <= 1'b1;
                hold          = HOLD_OFF_CYCLES - 1;
                pressure_done = 1'b1;
            end
            else
            begin
                n = pick_idle();
                out_stall <= (n != 0);
                hold = (n > 0) ? n - 1 : 0;
            end
        end
    end

    initial
    begin : stimulus
        int r;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty message straight out of reset, data byte must be ignored
        send(CMD_FINISH, 8'hFF);
        // back-to-back empty message with the opposite junk byte
        send(CMD_FINISH, 8'h00);
        // classic three-byte message
        send(CMD_ABSORB, 8'h61);
        send(CMD_ABSORB, 8'h62);
        send(CMD_ABSORB, 8'h63);
        send(CMD_FINISH, 8'h5A);
        // single-byte extremes
        send(CMD_ABSORB, 8'h00);
        send(CMD_FINISH, 8'hA5);
        send(CMD_ABSORB, 8'hFF);
        send(CMD_FINISH, 8'h00);
        // alternating bit patterns across a word boundary
        send(CMD_ABSORB, 8'h80);
        send(CMD_ABSORB, 8'h7F);
        send(CMD_ABSORB, 8'h55);
        send(CMD_ABSORB, 8'hAA);
        send(CMD_ABSORB, 8'h01);
        send(CMD_FINISH, 8'hFE);

        // random messages, lengths weighted toward the padding corners:
        // around 55/56 bytes (extra length block), 64 (exact block), 120
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send_message($urandom_range(0, 8));
            else if (r == 4)
                send_message($urandom_range(53, 58));
            else if (r == 5)
                send_message($urandom_range(61, 66));
            else if (r == 6)
                send_message($urandom_range(117, 122));
            else if (r < 9)
                send_message($urandom_range(0, 40));
            else
            begin
                // noise: a short run of random commands, can split a message
                repeat ($urandom_range(1, 4))
                    send(hash_cmd_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
        // close any message left open by noise so its digest is checked too
        send(CMD_FINISH, 8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/sha1bs_pkg.sv
rtl/sha1bs_ram.sv
rtl/sha1bs_core.sv
rtl/sha1_byte_stream_hasher.sv
tb/sha1_tb_pkg.sv
tb/sha1_digest_checker.sv
tb/tb.sv
